[rtl/hsqm_pkg.sv]
// Shared types and constants for the Huffman sorted queue merger.
// Used by hsqm_cell and huffman_sorted_queue_merger_top; no dependencies.
`default_nettype none

package hsqm_pkg;

  localparam int unsigned QueueDepth = 256;
  localparam int unsigned CountW     = $clog2(QueueDepth + 1);
  localparam int unsigned FreqW      = 32;
  localparam int unsigned IdW        = 9;
  localparam int unsigned SymW       = 8;
  localparam int unsigned CtrW       = 8;
  localparam int unsigned LenW       = 9;
  localparam int unsigned StatusW    = 2;
  localparam int unsigned InDataW    = 40;  // symbol + frequency, byte padded
  localparam int unsigned OutDataW   = 72;  // 68 bits of fields, byte padded

  localparam logic [IdW-1:0] InternalBase = IdW'(256);

  typedef enum logic [StatusW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_SHORT = 2'd2
  } status_e;

  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_COMBINE = 1'b1
  } mode_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_POP2   = 2'd2
  } cell_op_e;

  typedef enum logic {
    S_IDLE  = 1'b0,
    S_MERGE = 1'b1
  } state_e;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    cell_op_e             op;
    logic [FreqW-1:0]     freq;
    logic [IdW-1:0]       id;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[rtl/hsqm_cell.sv]
// One slot of the sorted node chain: holds a (frequency, id) pair.
// Depends on hsqm_pkg.
`default_nettype none

module hsqm_cell (
  input  logic                        clk_i,
  input  hsqm_pkg::cell_ctrl_t        ctrl_i,
  input  logic                        occ_i,         // slot holds a live entry
  input  logic                        lower_lt_i,    // neighbour below keeps its entry
  input  logic [hsqm_pkg::FreqW-1:0]  lower_freq_i,
  input  logic [hsqm_pkg::IdW-1:0]    lower_id_i,
  input  logic [hsqm_pkg::FreqW-1:0]  upper_freq_i,  // two slots up
  input  logic [hsqm_pkg::IdW-1:0]    upper_id_i,
  output logic [hsqm_pkg::FreqW-1:0]  freq_o,
  output logic [hsqm_pkg::IdW-1:0]    id_o,
  output logic                        lt_o
);
  import hsqm_pkg::*;

  logic [FreqW-1:0] freq_q, freq_d;
  logic [IdW-1:0]   id_q, id_d;

  // Live entry strictly below the new key stays put on insert.
  assign lt_o   = occ_i && (freq_q < ctrl_i.freq);
  assign freq_o = freq_q;
  assign id_o   = id_q;

  always_comb begin
    freq_d = freq_q;
    id_d   = id_q;
    unique case (ctrl_i.op)
      CELL_HOLD: begin
      end
      CELL_INSERT: begin
        if (!lt_o) begin
          if (lower_lt_i) begin
            freq_d = ctrl_i.freq;
            id_d   = ctrl_i.id;
          end else begin
            freq_d = lower_freq_i;
            id_d   = lower_id_i;
          end
        end
      end
      CELL_POP2: begin
        freq_d = upper_freq_i;
        id_d   = upper_id_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    freq_q <= freq_d;
    id_q   <= id_d;
  end

endmodule

`default_nettype wire

[rtl/huffman_sorted_queue_merger_top.sv]
// Top level of the Huffman sorted queue merger: stream ports, sequencer
// and the row of hsqm_cell slots. Depends on hsqm_pkg and hsqm_cell.
`default_nettype none

// The queue is a row of QueueDepth cells kept in ascending frequency order,
// slot 0 holding the smallest (the tail, i.e. the next to leave). Among equal
// frequencies the newest entry sits nearest slot 0. On an insert each cell
// compares its own frequency with the broadcast key and either keeps its
// entry, takes the key, or takes its lower neighbour's entry. A combine
// first reads slots 0 and 1 (left and right), forms the saturating sum and
// shifts the row down by two; then, in S_MERGE and once the output register
// is free, it inserts the new internal node (id 256 plus an 8-bit wrapping
// counter). Errored items (insert when full, combine with fewer than two
// entries) are answered from S_IDLE and change nothing. A finished result
// sits in an output register, so the next item is taken while it waits as
// long as the register is freed in the same cycle. One result item per input
// item; status travels in m_axis_tuser.
module huffman_sorted_queue_merger_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [hsqm_pkg::InDataW-1:0]   s_axis_tdata_i,   // symbol[7:0], frequency[39:8]
  input  logic [0:0]                     s_axis_tuser_i,   // mode[0]
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [hsqm_pkg::OutDataW-1:0]  m_axis_tdata_o,   // node_id[8:0], left_id[17:9],
                                                           // right_id[26:18],
                                                           // sum_frequency[58:27],
                                                           // queue_length[67:59], zero pad
  output logic [hsqm_pkg::StatusW-1:0]   m_axis_tuser_o    // status[1:0]
);
  import hsqm_pkg::*;

  // input fields
  logic [SymW-1:0]  in_symbol;
  logic [FreqW-1:0] in_freq;
  mode_e            in_mode;
  assign in_symbol = s_axis_tdata_i[SymW-1:0];
  assign in_freq   = s_axis_tdata_i[SymW+FreqW-1:SymW];
  assign in_mode   = mode_e'(s_axis_tuser_i[0]);

  // control state
  state_e            state_q, state_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CtrW-1:0]   ctr_q, ctr_d;
  logic              m_valid_q, m_valid_d;

  // pending merge and output payload
  logic [FreqW-1:0]  pend_freq_q, pend_freq_d;
  logic [IdW-1:0]    pend_left_q, pend_left_d;
  logic [IdW-1:0]    pend_right_q, pend_right_d;
  status_e           m_status_q, m_status_d;
  logic [IdW-1:0]    m_node_q, m_node_d;
  logic [IdW-1:0]    m_left_q, m_left_d;
  logic [IdW-1:0]    m_right_q, m_right_d;
  logic [FreqW-1:0]  m_sum_q, m_sum_d;
  logic [LenW-1:0]   m_len_q, m_len_d;

  cell_ctrl_t        ctrl;
  logic              accept;
  logic              out_free;
  logic [FreqW:0]    raw_sum;

  logic [FreqW-1:0]  cell_freq [QueueDepth];
  logic [IdW-1:0]    cell_id   [QueueDepth];
  logic              cell_lt   [QueueDepth];

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == S_IDLE) && out_free;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign raw_sum         = {1'b0, cell_freq[0]} + {1'b0, cell_freq[1]};

  // ---------------------------------------------------------------- cell row
  for (genvar k = 0; k < QueueDepth; k++) begin : g_cell
    logic             occ;
    logic             lower_lt;
    logic [FreqW-1:0] lower_freq;
    logic [IdW-1:0]   lower_id;
    logic [FreqW-1:0] upper_freq;
    logic [IdW-1:0]   upper_id;

    assign occ = CountW'(k) < count_q;

    if (k == 0) begin : g_bottom
      assign lower_lt   = 1'b1;
      assign lower_freq = ctrl.freq;
      assign lower_id   = ctrl.id;
    end else begin : g_mid
      assign lower_lt   = cell_lt[k-1];
      assign lower_freq = cell_freq[k-1];
      assign lower_id   = cell_id[k-1];
    end

    if (k + 2 < QueueDepth) begin : g_up
      assign upper_freq = cell_freq[k+2];
      assign upper_id   = cell_id[k+2];
    end else begin : g_top
      assign upper_freq = cell_freq[k];
      assign upper_id   = cell_id[k];
    end

    hsqm_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occ_i       (occ),
      .lower_lt_i  (lower_lt),
      .lower_freq_i(lower_freq),
      .lower_id_i  (lower_id),
      .upper_freq_i(upper_freq),
      .upper_id_i  (upper_id),
      .freq_o      (cell_freq[k]),
      .id_o        (cell_id[k]),
      .lt_o        (cell_lt[k])
    );
  end

  // --------------------------------------------------------------- sequencer
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    ctr_d        = ctr_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    pend_freq_d  = pend_freq_q;
    pend_left_d  = pend_left_q;
    pend_right_d = pend_right_q;
    m_status_d   = m_status_q;
    m_node_d     = m_node_q;
    m_left_d     = m_left_q;
    m_right_d    = m_right_q;
    m_sum_d      = m_sum_q;
    m_len_d      = m_len_q;
    ctrl.op      = CELL_HOLD;
    ctrl.freq    = in_freq;
    ctrl.id      = {1'b0, in_symbol};

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          m_left_d  = '0;
          m_right_d = '0;
          m_sum_d   = '0;
          m_node_d  = '0;
          if (in_mode == MODE_INSERT) begin
            m_valid_d = 1'b1;
            if (count_q >= CountW'(QueueDepth)) begin
              m_status_d = ST_FULL;
            end else begin
              ctrl.op    = CELL_INSERT;
              count_d    = count_q + CountW'(1);
              m_status_d = ST_OK;
              m_node_d   = {1'b0, in_symbol};
            end
            m_len_d = LenW'(count_d);
          end else if (count_q < CountW'(2)) begin
            m_valid_d  = 1'b1;
            m_status_d = ST_SHORT;
            m_len_d    = LenW'(count_q);
          end else begin
            // pop the two smallest; the merged node goes back in S_MERGE
            ctrl.op      = CELL_POP2;
            count_d      = count_q - CountW'(2);
            pend_left_d  = cell_id[0];
            pend_right_d = cell_id[1];
            pend_freq_d  = raw_sum[FreqW] ? '1 : raw_sum[FreqW-1:0];
            state_d      = S_MERGE;
          end
        end
      end
      S_MERGE: begin
        ctrl.freq = pend_freq_q;
        ctrl.id   = InternalBase + IdW'(ctr_q);
        if (out_free) begin
          ctrl.op    = CELL_INSERT;
          count_d    = count_q + CountW'(1);
          ctr_d      = ctr_q + CtrW'(1);
          m_valid_d  = 1'b1;
          m_status_d = ST_OK;
          m_node_d   = ctrl.id;
          m_left_d   = pend_left_q;
          m_right_d  = pend_right_q;
          m_sum_d    = pend_freq_q;
          m_len_d    = LenW'(count_d);
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      ctr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ctr_q     <= ctr_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_freq_q  <= pend_freq_d;
    pend_left_q  <= pend_left_d;
    pend_right_q <= pend_right_d;
    m_status_q   <= m_status_d;
    m_node_q     <= m_node_d;
    m_left_q     <= m_left_d;
    m_right_q    <= m_right_d;
    m_sum_q      <= m_sum_d;
    m_len_q      <= m_len_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tdata_o  = {4'b0, m_len_q, m_sum_q, m_right_q, m_left_q, m_node_q};

endmodule

`default_nettype wire

[tb/sv/tb_huffman_sorted_queue_merger_top.sv]
// Self-checking testbench for huffman_sorted_queue_merger_top: a predictor,
// a burst driver and a stalling monitor on the stream ports.
// Depends on hsqm_pkg and the RTL of the merger.
`default_nettype none

module tb_huffman_sorted_queue_merger_top;
  import hsqm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // One input item: what the sender puts on tuser and tdata
  typedef struct packed {
    mode_e            mode;
    logic [SymW-1:0]  symbol;
    logic [FreqW-1:0] freq;
  } queue_item_t;

  // One result item, fields as the block reports them
  typedef struct packed {
    status_e          status;
    logic [IdW-1:0]   node_id;
    logic [IdW-1:0]   left_id;
    logic [IdW-1:0]   right_id;
    logic [FreqW-1:0] sum_freq;
    logic [LenW-1:0]  qlen;
  } merge_result_t;

  // Receiver back-pressure styles, drawn at random by the monitor
  typedef enum int {
    RX_OPEN   = 0,  // always ready
    RX_CHOPPY = 1,  // ready on a coin toss
    RX_LUMPY  = 2   // mostly ready, now and then a long stall
  } rx_style_e;

  localparam int unsigned ClkHalf  = 5;
  localparam int unsigned DrainPad = 20;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_valid = 1'b0;
  logic                s_ready;
  logic [InDataW-1:0]  s_data = '0;
  logic [0:0]          s_user = '0;
  logic                m_valid;
  logic                m_ready = 1'b0;
  logic [OutDataW-1:0] m_data;
  logic [StatusW-1:0]  m_user;

  huffman_sorted_queue_merger_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_ready),
    .s_axis_tdata_i  (s_data),   // symbol[7:0], frequency[39:8]
    .s_axis_tuser_i  (s_user),   // mode[0]
    .m_axis_tvalid_o (m_valid),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_data),   // node_id, left_id, right_id, sum_frequency, queue_length
    .m_axis_tuser_o  (m_user)    // status[1:0]
  );

  initial begin
    forever #ClkHalf clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Predictor: shadow copy of the sorted node queue. Position 0 holds the
  // largest frequency, the tail (fill-1) the smallest, i.e. next to leave.
  // ---------------------------------------------------------------------------
  logic [FreqW-1:0] shadow_freq [QueueDepth];
  logic [IdW-1:0]   shadow_node [QueueDepth];
  int unsigned      shadow_fill;
  logic [CtrW-1:0]  merge_ctr;

  // tallies for the closing summary
  int unsigned n_full, n_short, n_merged, n_saturated, n_ctr_wraps;

  // Sorted insert: goes behind every entry of greater or equal frequency,
  // so among ties the newest sits at the tail and leaves first.
  function automatic void stow_node(input logic [FreqW-1:0] f, input logic [IdW-1:0] id);
    int unsigned pos;
    pos = 0;
    while (pos < shadow_fill && shadow_freq[pos] >= f) pos++;
    for (int unsigned k = shadow_fill; k > pos; k--) begin
      shadow_freq[k] = shadow_freq[k-1];
      shadow_node[k] = shadow_node[k-1];
    end
    shadow_freq[pos] = f;
    shadow_node[pos] = id;
    shadow_fill++;
  endfunction

  function automatic merge_result_t apply_queue_item(input queue_item_t it);
    merge_result_t   r;
    logic [FreqW:0]  wide;
    r = '{status: ST_OK, default: '0};
    if (it.mode == MODE_INSERT) begin
      if (shadow_fill >= QueueDepth) begin
        r.status = ST_FULL;
        n_full++;
      end else begin
        stow_node(it.freq, IdW'(it.symbol));
        r.node_id = IdW'(it.symbol);
      end
    end else if (shadow_fill < 2) begin
      r.status = ST_SHORT;
      n_short++;
    end else begin
      r.left_id  = shadow_node[shadow_fill-1];
      r.right_id = shadow_node[shadow_fill-2];
      wide = {1'b0, shadow_freq[shadow_fill-1]} + {1'b0, shadow_freq[shadow_fill-2]};
      shadow_fill -= 2;
      // saturate rather than wrap
      r.sum_freq = wide[FreqW] ? '1 : wide[FreqW-1:0];
      if (wide[FreqW]) n_saturated++;
      r.node_id = InternalBase + IdW'(merge_ctr);
      if (merge_ctr == '1) n_ctr_wraps++;
      merge_ctr++;
      n_merged++;
      stow_node(r.sum_freq, r.node_id);
    end
    r.qlen = LenW'(shadow_fill);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus store and expected results
  // ---------------------------------------------------------------------------
  queue_item_t   pending_items[$];
  merge_result_t due_results[$];
  int unsigned   err_count;
  int unsigned   n_checked;

  task automatic add_leaf(input logic [SymW-1:0] sym, input logic [FreqW-1:0] f);
    pending_items.push_back('{MODE_INSERT, sym, f});
  endtask

  // symbol and frequency are don't-care on a combine; drive junk there
  task automatic add_merge();
    pending_items.push_back('{MODE_COMBINE, SymW'($urandom), FreqW'($urandom)});
  endtask

  // Frequency mix: small values for plenty of ties, full range, and values
  // near the top so that sums saturate.
  task automatic add_random_leaf();
    logic [FreqW-1:0] f;
    case ($urandom_range(0, 9))
      0, 1, 2: f = FreqW'($urandom_range(0, 7));
      3:       f = FreqW'($urandom_range(0, 1000));
      4, 5:    f = 32'hFFFF_FF00 | FreqW'($urandom_range(0, 255));
      default: f = FreqW'($urandom);
    endcase
    add_leaf(SymW'($urandom_range(0, 255)), f);
  endtask

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    err_count++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of items with random gaps; valid is held until taken.
  // ---------------------------------------------------------------------------
  queue_item_t in_flight;
  int unsigned burst_left, gap_left, n_sent;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid    <= 1'b0;
      s_data     <= '0;
      s_user     <= '0;
      burst_left = 1;
      gap_left   = 0;
    end else begin
      if (s_valid && s_ready) begin
        due_results.push_back(apply_queue_item(in_flight));
        n_sent++;
      end
      if (!s_valid || s_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          in_flight = pending_items.pop_front();
          s_valid <= 1'b1;
          s_user  <= in_flight.mode;
          s_data  <= {in_flight.freq, in_flight.symbol};
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left--;
          end
        end else begin
          s_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each taken result against the oldest expectation and
  // drives tready on a pattern of its own.
  // ---------------------------------------------------------------------------
  rx_style_e   rx_style;
  int unsigned rx_cycle, rx_hold;
  merge_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_ready  <= 1'b0;
      rx_style = RX_OPEN;
      rx_cycle = 0;
      rx_hold  = 0;
    end else begin
      if (m_valid && m_ready) begin
        n_checked++;
        if (due_results.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, tuser %0d tdata %h",
                                    m_user, m_data));
        end else begin
          want = due_results.pop_front();
          if (m_user != want.status)
            report_mismatch($sformatf("status %0d, want %0d", m_user, want.status));
          if (m_data[8:0] != want.node_id)
            report_mismatch($sformatf("node_id %0d, want %0d", m_data[8:0], want.node_id));
          if (m_data[17:9] != want.left_id)
            report_mismatch($sformatf("left_id %0d, want %0d", m_data[17:9], want.left_id));
          if (m_data[26:18] != want.right_id)
            report_mismatch($sformatf("right_id %0d, want %0d", m_data[26:18], want.right_id));
          if (m_data[58:27] != want.sum_freq)
            report_mismatch($sformatf("sum_frequency %h, want %h", m_data[58:27],
                                      want.sum_freq));
          if (m_data[67:59] != want.qlen)
            report_mismatch($sformatf("queue_length %0d, want %0d", m_data[67:59], want.qlen));
        end
      end

      if (rx_cycle == 0) rx_style = rx_style_e'($urandom_range(0, 2));
      rx_cycle = (rx_cycle + 1) % 128;
      if (rx_hold > 0) begin
        rx_hold--;
        m_ready <= 1'b0;
      end else begin
        case (rx_style)
          RX_OPEN:   m_ready <= 1'b1;
          RX_CHOPPY: m_ready <= 1'($urandom_range(0, 1));
          default: begin
            if ($urandom_range(0, 7) == 0) begin
              rx_hold = $urandom_range(1, 12);
              m_ready <= 1'b0;
            end else begin
              m_ready <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: directed items, then fill / drain / mixed random phases.
  // ---------------------------------------------------------------------------
  initial begin
    shadow_fill = 0;
    merge_ctr   = '0;

    // Directed part
    add_merge();                          // combine on an empty queue
    add_leaf(8'h00, 32'h0000_0000);
    add_merge();                          // combine with a single entry
    add_leaf(8'hFF, 32'hFFFF_FFFF);
    add_merge();                          // 0 + max, no overflow yet
    add_leaf(8'h80, 32'hFFFF_FFFF);
    add_merge();                          // max + max saturates
    add_leaf(8'h01, 32'd5);               // three ties: newest must leave first
    add_leaf(8'h02, 32'd5);
    add_leaf(8'h03, 32'd5);
    add_merge();
    add_merge();
    add_leaf(8'hAA, 32'hAAAA_AAAA);       // alternating bit patterns
    add_leaf(8'h55, 32'h5555_5555);
    add_merge();
    add_merge();
    add_merge();
    add_merge();
    add_merge();                          // down to one entry again
    add_leaf(8'h7F, 32'h8000_0000);

    // Fill past the top so that full-queue inserts show up
    repeat (QueueDepth + 6) add_random_leaf();
    // Drain to a single node, then a couple of short combines; with the
    // directed merges this takes the id counter through its wrap
    repeat (QueueDepth + 2) add_merge();
    // Mixed traffic, leaning towards inserts
    repeat (130) begin
      if ($urandom_range(0, 9) < 6) add_random_leaf();
      else add_merge();
    end

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_items.size() > 0 || s_valid) @(posedge clk_i);
    while (due_results.size() > 0) @(posedge clk_i);
    repeat (DrainPad) @(posedge clk_i);

    if (due_results.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", due_results.size()));

    $display("Sent %0d items, checked %0d results; %0d merges (%0d saturated),",
             n_sent, n_checked, n_merged, n_saturated);
    $display("%0d full-queue inserts, %0d short combines, %0d id counter wraps.",
             n_full, n_short, n_ctr_wraps);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~700 items)
  initial begin
    #2_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

[filelist.f]
rtl/hsqm_pkg.sv
rtl/hsqm_cell.sv
rtl/huffman_sorted_queue_merger_top.sv
tb/sv/tb_huffman_sorted_queue_merger_top.sv
